[sv/top_k_pkg.sv]
`timescale 1ns / 1ps

package top_k_pkg;

    localparam int VALUE_W = 32;
    localparam int KEEP_W  = 5;
    localparam logic [KEEP_W-1:0] KEEP_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      batch_end;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] kept_value;
        logic                      final_result;
    } out_item_t;

    typedef struct packed {
        logic insert;
        logic load_out;
    } tk_cmd_t;

    typedef struct packed {
        logic keep_nonzero;
        logic count_one;
    } tk_status_t;

endpackage

[sv/top_k_ctrl.sv]
`timescale 1ns / 1ps

module top_k_ctrl
    import top_k_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       batch_end,
    output logic       out_valid,
    input  logic       out_ready,
    output tk_cmd_t    cmd,
    input  tk_status_t status
);

    typedef enum logic {
        S_RUN,
        S_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_RUN:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.insert = 1'b1;
                    if (batch_end && status.keep_nonzero)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.count_one)
                    begin
                        state_next = S_RUN;
                    end
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[sv/top_k_dp.sv]
`timescale 1ns / 1ps

module top_k_dp
    import top_k_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [KEEP_W-1:0]         cfg_wdata,
    input  logic signed [VALUE_W-1:0] sample_value,
    input  tk_cmd_t                   cmd,
    output tk_status_t                status,
    output out_item_t                 out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LIM_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

    // Entries are held in descending order; the valid ones sit below count_reg.
    logic signed [VALUE_W-1:0] entry_reg [CAPACITY];
    logic signed [VALUE_W-1:0] entry_next [CAPACITY];
    logic [CAPACITY-1:0]       keep_old;
    logic [KEEP_W-1:0]         keep_count_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [LIM_W-1:0]          keep_ext;
    logic [LIM_W-1:0]          limit_ext;
    logic [CNT_W-1:0]          limit;
    logic [CNT_W:0]            count_inc;
    logic [CNT_W-1:0]          count_dec;
    logic [IDX_W-1:0]          rd_idx;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_final_reg;

    always_comb
    begin
        keep_ext  = LIM_W'(keep_count_reg);
        limit_ext = (keep_ext > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : keep_ext;
        limit     = CNT_W'(limit_ext);
        count_inc = {1'b0, count_reg} + 1'b1;
        count_dec = count_reg - 1'b1;
        rd_idx    = count_dec[IDX_W-1:0];
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            keep_old[i] = (CNT_W'(i) < count_reg) && (entry_reg[i] >= sample_value);
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (keep_old[i])
            begin
                entry_next[i] = entry_reg[i];
            end
            else if (i == 0)
            begin
                entry_next[i] = sample_value;
            end
            else if (keep_old[(i == 0) ? 0 : i - 1])
            begin
                entry_next[i] = sample_value;
            end
            else
            begin
                entry_next[i] = entry_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = (count_inc > {1'b0, limit}) ? limit : count_inc[CNT_W-1:0];
        end
        else if (cmd.load_out)
        begin
            count_next = count_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KEEP_COUNT_RESET;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                keep_count_reg <= cfg_wdata;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                entry_reg[i] <= entry_next[i];
            end
        end
        if (cmd.load_out)
        begin
            out_value_reg <= entry_reg[rd_idx];
            out_final_reg <= (count_reg == CNT_W'(1));
        end
    end

    assign status.keep_nonzero  = (limit != '0);
    assign status.count_one     = (count_reg == CNT_W'(1));
    assign out_data.kept_value   = out_value_reg;
    assign out_data.final_result = out_final_reg;

endmodule

[sv/top_k_largest_select.sv]
`timescale 1ns / 1ps

// Keeps the keep_count largest signed values of a batch and emits them in ascending order.
// The input channel (in_valid, in_ready, in_data) carries one value per beat; the beat
// with batch_end set closes the batch. During a batch one beat is taken every cycle,
// since each value is inserted in sorted order over all kept entries. After the closing
// beat the block drains the kept values, smallest first, one beat per cycle while the
// receiver takes every beat, on the output channel (out_valid, out_ready, out_data), and
// flags the last one with final_result. Each result goes from the drain state through the
// output register. While draining, in_ready stays low until the last kept value is loaded,
// later if the receiver stalls. The output register keeps the last result until it is
// taken while new input beats are already accepted. A keep_count of zero, or a batch that
// keeps nothing, produces no output beats. The user must write keep_count through cfg_we
// and cfg_wdata only while the block is idle; the block does not enforce this. Values
// above CAPACITY act as CAPACITY. Reset empties the store and sets keep_count to 16.
module top_k_largest_select
    import top_k_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [KEEP_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data
);

    tk_cmd_t    cmd;
    tk_status_t status;

    top_k_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .batch_end (in_data.batch_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    top_k_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .sample_value (in_data.sample_value),
        .cmd          (cmd),
        .status       (status),
        .out_data     (out_data)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import top_k_pkg::*;

    localparam int STORE_DEPTH    = 16;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int BEATS_PER_STEP = 26;

    class top_k_tracker;
        logic [KEEP_W-1:0]         keep_count;
        logic signed [VALUE_W-1:0] kept[$];
        out_item_t                 pending[$];
        int                        errors;
        int                        checked;

        function new();
            keep_count = KEEP_COUNT_RESET;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_keep(logic [KEEP_W-1:0] value);
            keep_count = value;
        endfunction

        function void take_sample(in_item_t beat);
            int        limit;
            int        pos;
            out_item_t res;
            limit = (keep_count > STORE_DEPTH) ? STORE_DEPTH : int'(keep_count);
            pos = 0;
            while (pos < kept.size() && kept[pos] <= beat.sample_value)
            begin
                pos++;
            end
            kept.insert(pos, beat.sample_value);
            while (kept.size() > limit)
            begin
                void'(kept.pop_front());
            end
            if (beat.batch_end)
            begin
                foreach (kept[i])
                begin
                    res.kept_value   = kept[i];
                    res.final_result = (i == kept.size() - 1);
                    pending.insert(pending.size(), res);
                end
                kept.delete();
            end
        endfunction

        function void check_emitted(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat: kept_value %0d, final_result %0b",
                       got.kept_value, got.final_result);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.kept_value !== want.kept_value)
            begin
                $error("kept_value: expected %0d, got %0d", want.kept_value, got.kept_value);
                errors++;
            end
            if (got.final_result !== want.final_result)
            begin
                $error("final_result: expected %0b, got %0b",
                       want.final_result, got.final_result);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [KEEP_W-1:0] cfg_wdata;
    logic              in_valid;
    logic              in_ready;
    in_item_t          in_data;
    logic              out_valid;
    logic              out_ready;
    out_item_t         out_data;

    top_k_tracker kept_model;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           cycle_count;
    int           beats_sent;
    int           batches_closed;
    int           keep_writes;

    top_k_largest_select #(
        .CAPACITY(STORE_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            kept_model.check_emitted(out_data);
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_beat(input in_item_t beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        kept_model.take_sample(beat);
        beats_sent++;
        if (beat.batch_end)
        begin
            batches_closed++;
        end
    endtask

    task automatic send_value(input logic signed [VALUE_W-1:0] value, input logic last);
        in_item_t beat;
        beat.sample_value = value;
        beat.batch_end    = last;
        send_beat(beat);
    endtask

    task automatic write_keep(input logic [KEEP_W-1:0] value);
        in_valid <= 1'b0;
        while (kept_model.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        kept_model.set_keep(value);
        keep_writes++;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] value;
        case ($urandom_range(9))
            0: value = 32'sh8000_0000;
            1: value = 32'sh7fff_ffff;
            2: value = $signed($urandom_range(2)) - 1;
            3, 4: value = $signed($urandom_range(15)) - 8;
            default: value = $urandom;
        endcase
        return value;
    endfunction

    task automatic send_batch(input int length);
        for (int i = 0; i < length; i++)
        begin
            send_value(pick_value(), i == length - 1);
        end
    endtask

    initial
    begin
        int                step_beats;
        int                length;
        logic [KEEP_W-1:0] keep_plan[12];

        kept_model     = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycle_count    = 0;
        beats_sent     = 0;
        batches_closed = 0;
        keep_writes    = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = KEEP_COUNT_RESET;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A setting above the store depth saturates, so only the 16 largest survive.
        write_keep(5'd31);
        send_value(32'sh8000_0000, 1'b0);
        send_value(32'sh7fff_ffff, 1'b0);
        send_value(32'sd0, 1'b0);
        send_value(-32'sd1, 1'b0);
        send_value(32'sd1, 1'b0);
        send_value(32'sd5, 1'b0);
        send_value(32'sd5, 1'b0);
        send_value(32'sh8000_0000, 1'b0);
        send_value(32'sh7fff_ffff, 1'b0);
        send_value(32'sd100, 1'b0);
        send_value(-32'sd100, 1'b0);
        send_value(32'sh5555_5555, 1'b0);
        send_value(32'shaaaa_aaaa, 1'b0);
        send_value(32'sd7, 1'b0);
        send_value(32'sd5, 1'b0);
        send_value(-32'sd7, 1'b0);
        send_value(32'sd3, 1'b0);
        send_value(32'sd2, 1'b1);

        // With nothing kept the closing beat produces no output.
        write_keep(5'd0);
        send_value(32'sd42, 1'b0);
        send_value(-32'sd42, 1'b1);

        // Lowering the setting in the middle of a batch trims the store at the next beat.
        write_keep(5'd3);
        send_value(32'sd10, 1'b0);
        send_value(32'sd20, 1'b0);
        send_value(32'sd30, 1'b0);
        write_keep(5'd1);
        send_value(32'sd5, 1'b0);
        send_value(32'sd1, 1'b1);

        keep_plan = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd17, 5'd2, 5'd0, 5'd8,
                      5'd15, 5'd0, 5'd31, 5'd16};
        keep_plan[6] = KEEP_W'($urandom_range(31));
        keep_plan[9] = KEEP_W'($urandom_range(31));

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 28 : (phase == 1) ? 75 : 0;
            recv_stall_pct = (phase == 0) ? 75 : (phase == 1) ? 28 : 0;
            for (int step = 0; step < 4; step++)
            begin
                write_keep(keep_plan[phase * 4 + step]);
                step_beats = 0;
                while (step_beats < BEATS_PER_STEP)
                begin
                    length = ($urandom_range(3) == 0) ? $urandom_range(1, 3)
                                                      : $urandom_range(4, 24);
                    send_batch(length);
                    step_beats += length;
                end
            end
        end

        in_valid <= 1'b0;
        while (kept_model.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d input beats in %0d batches over %0d keep_count settings,",
                 beats_sent, batches_closed, keep_writes);
        $display("checked %0d result beats with and without handshake stalls.",
                 kept_model.checked);
        if (kept_model.errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
